// ----- hdl/ism_pkg.sv -----
// Shared beat types and field widths for the interval schedule selector.
`timescale 1ns / 1ps

package ism_pkg;

    localparam int FIELD_TIME_W = 16;
    localparam int INDEX_W      = 6;

    typedef struct packed {
        logic [FIELD_TIME_W-1:0] start_time;
        logic [FIELD_TIME_W-1:0] end_time;
        logic                    last;
    } t_in_item;

    typedef struct packed {
        logic [INDEX_W-1:0] meeting_index;
        logic               is_last;
        logic               overflowed;
    } t_out_item;

endpackage

// ----- hdl/interval_schedule_selector.sv -----
// Top level: sorted interval store, insertion walk and greedy selection walk.
`timescale 1ns / 1ps

// Intervals arrive one beat each while busy is low; each is placed into an
// end-time-ordered memory by walking down from the tail one entry per cycle,
// shifting each stored interval with a later end (at most MAX_MEETINGS - 1)
// up by one entry. A beat that finds the memory full is dropped and sets the
// overflowed flag. The beat flagged last then starts a selection walk that
// reads the ordered memory once per cycle and holds busy until the final
// result is registered. Results leave on o_strobe for one cycle each,
// registered from the walk, and cannot be stalled; the final result is on
// the ports in the first cycle with busy low.

module interval_schedule_selector
    import ism_pkg::*;
#(
    parameter int MAX_MEETINGS = 32,
    parameter int TIME_BITS    = 16
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      start,
    output logic      busy,
    input  t_in_item  i_item,
    output logic      o_strobe,
    output t_out_item o_result
);

    localparam int SW = (MAX_MEETINGS > 1) ? $clog2(MAX_MEETINGS) : 1;
    localparam int CW = $clog2(MAX_MEETINGS + 1);
    localparam int TB = TIME_BITS;
    localparam int DW = SW + 2 * TB;

    typedef struct packed {
        logic [SW-1:0] slot;
        logic [TB-1:0] t_start;
        logic [TB-1:0] t_end;
    } t_entry;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_INS,
        ST_LOAD,
        ST_SEL,
        ST_FIN
    } t_state;

    t_state        r_state, n_state;
    logic [CW-1:0] r_count, n_count;
    logic          r_ovf, n_ovf;
    logic          r_fin, n_fin;
    t_entry        r_new, n_new;
    logic [SW-1:0] r_pos, n_pos;
    logic [SW-1:0] r_idx, n_idx;
    logic [TB-1:0] r_limit, n_limit;
    logic [SW-1:0] r_pend, n_pend;
    logic          r_have, n_have;
    logic          r_strobe, n_strobe;
    t_out_item     r_out, n_out;

    logic          we;
    logic [SW-1:0] waddr;
    t_entry        wdata;
    logic [SW-1:0] raddr;
    logic [DW-1:0] rdata_raw;
    t_entry        rd;
    logic [CW-1:0] count_m1;
    logic          pick;

    assign rd       = t_entry'(rdata_raw);
    assign count_m1 = r_count - CW'(1);
    assign pick     = (r_idx == '0) || (rd.t_start > r_limit);

    ism_store #(
        .DEPTH (MAX_MEETINGS),
        .AW    (SW),
        .DW    (DW)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (DW'(wdata)),
        .i_raddr (raddr),
        .o_rdata (rdata_raw)
    );

    always_comb begin
        n_state  = r_state;
        n_count  = r_count;
        n_ovf    = r_ovf;
        n_fin    = r_fin;
        n_new    = r_new;
        n_pos    = r_pos;
        n_idx    = r_idx;
        n_limit  = r_limit;
        n_pend   = r_pend;
        n_have   = r_have;
        n_strobe = 1'b0;
        n_out    = r_out;
        we       = 1'b0;
        waddr    = r_pos;
        wdata    = r_new;
        raddr    = count_m1[SW-1:0];
        case (r_state)
            ST_IDLE: begin
                if (start) begin
                    n_fin = i_item.last;
                    if (r_count < CW'(MAX_MEETINGS)) begin
                        n_new.slot    = r_count[SW-1:0];
                        n_new.t_start = TB'(i_item.start_time);
                        n_new.t_end   = TB'(i_item.end_time);
                        n_pos         = r_count[SW-1:0];
                        n_state       = ST_INS;
                    end else begin
                        n_ovf = 1'b1;
                        if (i_item.last) begin
                            n_state = ST_LOAD;
                        end
                    end
                end
            end
            ST_INS: begin
                raddr = r_pos - SW'(2);
                we    = 1'b1;
                if ((r_pos != '0) && (rd.t_end > r_new.t_end)) begin
                    wdata = rd;
                    n_pos = r_pos - SW'(1);
                end else begin
                    wdata   = r_new;
                    n_count = r_count + CW'(1);
                    n_state = r_fin ? ST_LOAD : ST_IDLE;
                end
            end
            ST_LOAD: begin
                raddr   = '0;
                n_idx   = '0;
                n_have  = 1'b0;
                n_state = ST_SEL;
            end
            ST_SEL: begin
                raddr = r_idx + SW'(1);
                if (pick) begin
                    n_limit = rd.t_end;
                    n_pend  = rd.slot;
                    n_have  = 1'b1;
                    if (r_have) begin
                        n_strobe            = 1'b1;
                        n_out.meeting_index = INDEX_W'(int'(r_pend) + 1);
                        n_out.is_last       = 1'b0;
                        n_out.overflowed    = r_ovf;
                    end
                end
                n_idx = r_idx + SW'(1);
                if (r_idx == count_m1[SW-1:0]) begin
                    n_state = ST_FIN;
                end
            end
            ST_FIN: begin
                n_strobe            = 1'b1;
                n_out.meeting_index = INDEX_W'(int'(r_pend) + 1);
                n_out.is_last       = 1'b1;
                n_out.overflowed    = r_ovf;
                n_count             = '0;
                n_ovf               = 1'b0;
                n_have              = 1'b0;
                n_state             = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_count  <= '0;
            r_ovf    <= 1'b0;
            r_fin    <= 1'b0;
            r_limit  <= '0;
            r_have   <= 1'b0;
            r_strobe <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_count  <= n_count;
            r_ovf    <= n_ovf;
            r_fin    <= n_fin;
            r_limit  <= n_limit;
            r_have   <= n_have;
            r_strobe <= n_strobe;
        end
        r_new  <= n_new;
        r_pos  <= n_pos;
        r_idx  <= n_idx;
        r_pend <= n_pend;
        r_out  <= n_out;
    end

    assign busy     = (r_state != ST_IDLE);
    assign o_strobe = r_strobe;
    assign o_result = r_out;

endmodule

// ----- hdl/ism_store.sv -----
// Single-port-write, single-port-read entry memory with registered read data.
`timescale 1ns / 1ps

module ism_store #(
    parameter int DEPTH = 32,
    parameter int AW    = 5,
    parameter int DW    = 37
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [DW-1:0] i_wdata,
    input  logic [AW-1:0] i_raddr,
    output logic [DW-1:0] o_rdata
);

    logic [DW-1:0] r_mem [DEPTH];
    logic [DW-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- dv/tb_interval_schedule_selector.sv -----
// Self-checking testbench for the interval schedule selector with a greedy pick check.
`timescale 1ns / 1ps

module tb_interval_schedule_selector
    import ism_pkg::*;
();

    localparam int MAX_MEETINGS = 32;
    localparam int CYCLE_LIMIT  = 200000;

    class schedule_scoreboard;
        logic [FIELD_TIME_W-1:0] start_at [MAX_MEETINGS];
        logic [FIELD_TIME_W-1:0] end_at [MAX_MEETINGS];
        int                      by_end [MAX_MEETINGS];
        int                      stored;
        bit                      dropped;
        logic [FIELD_TIME_W-1:0] last_end;
        t_out_item               expected_picks[$];
        int                      picks_made;
        int                      mismatches;

        task report_mismatch(input string what, input int got, input int want);
            $display("mismatch: %s got %0d want %0d at %0t", what, got, want, $realtime);
            mismatches++;
        endtask

        task note_interval(input t_in_item beat);
            int        pos;
            int        k;
            int        chosen[$];
            t_out_item pick;
            if (stored < MAX_MEETINGS) begin
                start_at[stored] = beat.start_time;
                end_at[stored]   = beat.end_time;
                pos = stored;
                while (pos > 0 && end_at[by_end[pos-1]] > end_at[stored]) begin
                    by_end[pos] = by_end[pos-1];
                    pos--;
                end
                by_end[pos] = stored;
                stored++;
            end else begin
                dropped = 1'b1;
            end
            if (!beat.last) return;
            chosen = {};
            chosen = {chosen, by_end[0]};
            last_end = end_at[by_end[0]];
            for (k = 1; k < stored; k++) begin
                if (start_at[by_end[k]] > last_end) begin
                    last_end = end_at[by_end[k]];
                    chosen = {chosen, by_end[k]};
                end
            end
            for (k = 0; k < chosen.size(); k++) begin
                pick.meeting_index = INDEX_W'(chosen[k] + 1);
                pick.is_last       = (k == chosen.size() - 1);
                pick.overflowed    = dropped;
                expected_picks = {expected_picks, pick};
                picks_made++;
            end
            stored  = 0;
            dropped = 1'b0;
        endtask

        task check_pick(input t_out_item got);
            t_out_item want;
            if (expected_picks.size() == 0) begin
                report_mismatch("result with nothing expected, index", got.meeting_index, 0);
                return;
            end
            want = expected_picks.pop_front();
            if (got.meeting_index !== want.meeting_index)
                report_mismatch("meeting_index", got.meeting_index, want.meeting_index);
            if (got.is_last !== want.is_last)
                report_mismatch("is_last", got.is_last, want.is_last);
            if (got.overflowed !== want.overflowed)
                report_mismatch("overflowed", got.overflowed, want.overflowed);
        endtask
    endclass

    logic      i_clk;
    logic      i_rst_n;
    logic      start;
    logic      busy;
    t_in_item  i_item;
    logic      o_strobe;
    t_out_item o_result;

    schedule_scoreboard sb;
    bit                 calm;
    int                 cycles;

    interval_schedule_selector dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .busy     (busy),
        .i_item   (i_item),
        .o_strobe (o_strobe),
        .o_result (o_result)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    initial cycles = 0;

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("[interval_schedule_selector] ERROR");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_strobe) sb.check_pick(o_result);
    end

    task send_interval(input t_in_item beat);
        int r;
        int gap;
        r   = $urandom_range(0, 99);
        gap = 0;
        if (!calm) begin
            if (r >= 90)      gap = $urandom_range(10, 60);
            else if (r >= 55) gap = $urandom_range(1, 3);
        end
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start  <= 1'b1;
        i_item <= beat;
        do @(posedge i_clk); while (busy);
        sb.note_interval(beat);
    endtask

    task send_fields(input logic [FIELD_TIME_W-1:0] s, input logic [FIELD_TIME_W-1:0] e,
                     input bit fin);
        t_in_item beat;
        beat.start_time = s;
        beat.end_time   = e;
        beat.last       = fin;
        send_interval(beat);
    endtask

    initial begin
        int                      set_no;
        int                      set_size;
        int                      n;
        int                      r;
        int                      random_items;
        bit                      narrow;
        logic [FIELD_TIME_W-1:0] s;
        logic [FIELD_TIME_W-1:0] e;

        sb      = new;
        calm    = 1'b0;
        start   = 1'b0;
        i_item  = '0;
        i_rst_n = 1'b0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // single-interval sets at the extremes
        send_fields(16'h0000, 16'h0000, 1'b1);
        send_fields(16'hFFFF, 16'hFFFF, 1'b1);
        send_fields(16'h0000, 16'hFFFF, 1'b1);
        // end ties, start equal to chosen end, start above end
        send_fields(16'd5, 16'd10, 1'b0);
        send_fields(16'd10, 16'd20, 1'b0);
        send_fields(16'd11, 16'd20, 1'b0);
        send_fields(16'd0, 16'd10, 1'b0);
        send_fields(16'hFFFF, 16'hFFFF, 1'b0);
        send_fields(16'hFFFF, 16'h0000, 1'b1);
        // back-to-back disjoint intervals, no idle
        calm = 1'b1;
        send_fields(16'd1, 16'd1, 1'b0);
        send_fields(16'd2, 16'd2, 1'b0);
        send_fields(16'd3, 16'd3, 1'b0);
        send_fields(16'hAAAA, 16'hAAAA, 1'b0);
        send_fields(16'h5555, 16'h5555, 1'b1);
        calm = 1'b0;

        random_items = 0;
        set_no       = 0;
        while (random_items < 145) begin
            r = $urandom_range(0, 99);
            if (set_no == 2)      set_size = MAX_MEETINGS + 1;
            else if (set_no == 5) set_size = MAX_MEETINGS + 2;
            else if (r < 80)      set_size = $urandom_range(1, 8);
            else if (r < 93)      set_size = $urandom_range(9, MAX_MEETINGS - 1);
            else                  set_size = $urandom_range(MAX_MEETINGS, MAX_MEETINGS + 4);
            calm   = ($urandom_range(0, 3) == 0);
            narrow = ($urandom_range(0, 1) == 0);
            for (n = 0; n < set_size; n++) begin
                r = $urandom_range(0, 99);
                if (r < 15) begin
                    s = FIELD_TIME_W'($urandom);
                    e = FIELD_TIME_W'($urandom);
                end else if (narrow) begin
                    s = FIELD_TIME_W'($urandom_range(0, 63));
                    e = FIELD_TIME_W'(s + $urandom_range(0, 15));
                end else begin
                    s = FIELD_TIME_W'($urandom_range(0, 65535));
                    e = FIELD_TIME_W'(s + $urandom_range(0, 65535 - s));
                end
                send_fields(s, e, n == set_size - 1);
                random_items++;
            end
            set_no++;
        end
        start <= 1'b0;

        while (sb.expected_picks.size() != 0) @(posedge i_clk);
        repeat (80) @(posedge i_clk);
        if (sb.mismatches == 0 && sb.expected_picks.size() == 0)
            $display("[interval_schedule_selector] OK");
        else
            $display("[interval_schedule_selector] ERROR");
        $finish;
    end

endmodule

// ----- sim.f -----
hdl/ism_pkg.sv
hdl/ism_store.sv
hdl/interval_schedule_selector.sv
dv/tb_interval_schedule_selector.sv
